// ===== rtl/cqf_pkg.sv =====
// Package for the circular queue FIFO: field widths, operation and status codes,
// sequencer states and default sizes.
// Stands alone; cqf_if and the top level refer to it by scoped names.
package cqf_pkg;

    // Field widths of the transaction payloads
    localparam int VALUE_W  = 32;
    localparam int SLOT_W   = 4;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int SLOTS_W  = 5;

    // Ring sizing: the slot count register saturates to this range
    localparam int SLOTS_MIN = 2;
    localparam int SLOTS_MAX = 16;
    localparam int DEPTH_DEF = 16;

    // Operation codes carried in the kind field
    localparam logic [KIND_W-1:0] KIND_ENQ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DEQ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TRAV = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TRAV_EMPTY = 2'd3;

    // Word returned by a dequeue on an empty queue
    localparam logic signed [VALUE_W-1:0] UNDERFLOW_VALUE = -32'sd1;

    // Sequencer states
    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_EXEC,
        SEQ_EMIT
    } seq_state_t;

endpackage

// ===== rtl/cqf_if.sv =====
// Valid/ready channel interfaces for the circular queue FIFO: the command
// channel into the block and the response channel out of it.
// Depends on cqf_pkg for the payload widths.
interface cqf_cmd_if;
    logic                               valid;
    logic                               ready;
    logic [cqf_pkg::KIND_W-1:0]         kind;
    logic signed [cqf_pkg::VALUE_W-1:0] data;

    modport source (output valid, output kind, output data, input ready);
    modport sink   (input valid, input kind, input data, output ready);
endinterface

interface cqf_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [cqf_pkg::VALUE_W-1:0] value;
    logic [cqf_pkg::SLOT_W-1:0]         slot_index;
    logic [cqf_pkg::STATUS_W-1:0]       status;
    logic                               last;
    logic                               is_empty;
    logic                               is_full;

    modport source (output valid, output value, output slot_index, output status,
                    output last, output is_empty, output is_full, input ready);
    modport sink   (input valid, input value, input slot_index, input status,
                    input last, input is_empty, input is_full, output ready);
endinterface

// ===== rtl/cqf_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cqf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/cqf_adv.sv =====
// Shared ring index unit: advances an index by one with wrap at the last
// used slot. Depends on nothing but its width parameter.
module cqf_adv #(
    parameter int IDX_W = 4
) (
    input  logic [IDX_W-1:0] idx,
    input  logic [IDX_W-1:0] last_slot,
    output logic [IDX_W-1:0] nxt
);

    logic wraps;

    // Wrap to slot zero after the last slot in use
    assign wraps = (idx == last_slot);
    assign nxt   = wraps ? '0 : idx + IDX_W'(1);

endmodule

// ===== rtl/circular_queue_fifo.sv =====
// Top level of the circular queue FIFO: slot count register, sequencer,
// response register, slot RAM and shared index unit.
// Depends on cqf_pkg, cqf_if, cqf_ram and cqf_adv.
//
//  Channel   Direction  Handshake          Payload
//  cmd       in         valid / ready      kind, data
//  rsp       out        valid / ready      value, slot_index, status, last,
//                                          is_empty, is_full
//  cfg       in         cfg_wr_en only     cfg_wr_data (slot count)
//
// An enqueue, an overflow, an underflow or an empty traverse is taken in IDLE
// and its result registered in EXEC. A dequeue goes on to EMIT, as the slot RAM
// has a registered read port. A traverse sends its held words from EMIT, one word
// per cycle through the single RAM read port and the shared index unit unless
// the response stalls. Reset is asynchronous and leaves the queue empty with RING
// slots. While the response is stalled the sequencer holds, and a new command is
// taken once the last result of the previous one is in the response register.
module circular_queue_fifo #(
    parameter int DEPTH = cqf_pkg::DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [cqf_pkg::SLOTS_W-1:0]  cfg_wr_data,
    cqf_cmd_if.sink                      cmd,
    cqf_rsp_if.source                    rsp
);

    localparam int RING  = (DEPTH < cqf_pkg::SLOTS_MAX) ? DEPTH : cqf_pkg::SLOTS_MAX;
    localparam int IDX_W = $clog2(RING);

    cqf_pkg::seq_state_t state_reg, state_next;

    logic [IDX_W-1:0] last_slot_reg, last_slot_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [IDX_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic             single_reg, single_next;
    logic [cqf_pkg::KIND_W-1:0]         kind_reg, kind_next;
    logic signed [cqf_pkg::VALUE_W-1:0] data_reg, data_next;

    logic                               rsp_valid_reg, rsp_valid_next;
    logic signed [cqf_pkg::VALUE_W-1:0] value_reg, value_next;
    logic [cqf_pkg::SLOT_W-1:0]         slot_reg, slot_next;
    logic [cqf_pkg::STATUS_W-1:0]       status_reg, status_next;
    logic                               last_reg, last_next;
    logic                               empty_reg, empty_next;
    logic                               full_reg, full_next;

    logic                        out_free;
    logic                        load;
    logic [IDX_W-1:0]            adv_in;
    logic [IDX_W-1:0]            adv_out;
    logic                        ram_we;
    logic                        ram_re;
    logic [IDX_W-1:0]            ram_waddr;
    logic [IDX_W-1:0]            ram_raddr;
    logic [cqf_pkg::VALUE_W-1:0] ram_rdata;
    logic                        q_empty;
    logic                        q_full;

    // Slot store
    cqf_ram #(
        .WIDTH (cqf_pkg::VALUE_W),
        .DEPTH (RING)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (data_reg),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Shared index advance unit
    cqf_adv #(
        .IDX_W (IDX_W)
    ) u_adv (
        .idx       (adv_in),
        .last_slot (last_slot_reg),
        .nxt       (adv_out)
    );

    // Slot count register written as the last slot index, saturated to the ring
    always_comb
    begin
        if (cfg_wr_data < cqf_pkg::SLOTS_W'(cqf_pkg::SLOTS_MIN))
        begin
            last_slot_next = IDX_W'(cqf_pkg::SLOTS_MIN - 1);
        end
        else if (cfg_wr_data > cqf_pkg::SLOTS_W'(RING))
        begin
            last_slot_next = IDX_W'(RING - 1);
        end
        else
        begin
            last_slot_next = IDX_W'(cfg_wr_data - cqf_pkg::SLOTS_W'(1));
        end
    end

    assign q_empty  = (count_reg == '0);
    assign q_full   = (count_reg == last_slot_reg);
    assign out_free = !rsp_valid_reg || rsp.ready;
    assign cmd.ready = (state_reg == cqf_pkg::SEQ_IDLE);

    // Sequencer: next state, queue pointers, RAM control and response load
    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        single_next = single_reg;
        kind_next   = kind_reg;
        data_next   = data_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = adv_out;
        ram_raddr   = adv_out;
        adv_in      = head_reg;
        load        = 1'b0;
        value_next  = value_reg;
        slot_next   = slot_reg;
        status_next = status_reg;
        last_next   = last_reg;
        empty_next  = empty_reg;
        full_next   = full_reg;

        unique case (state_reg)
            cqf_pkg::SEQ_IDLE:
            begin
                // Unused kind codes are taken and dropped
                if (cmd.valid && (cmd.kind == cqf_pkg::KIND_ENQ ||
                                  cmd.kind == cqf_pkg::KIND_DEQ ||
                                  cmd.kind == cqf_pkg::KIND_TRAV))
                begin
                    kind_next  = cmd.kind;
                    data_next  = cmd.data;
                    state_next = cqf_pkg::SEQ_EXEC;
                end
            end

            cqf_pkg::SEQ_EXEC:
            begin
                if (kind_reg == cqf_pkg::KIND_ENQ)
                begin
                    adv_in = tail_reg;
                    if (out_free)
                    begin
                        load        = 1'b1;
                        value_next  = data_reg;
                        last_next   = 1'b1;
                        empty_next  = 1'b0;
                        state_next  = cqf_pkg::SEQ_IDLE;
                        if (q_full)
                        begin
                            slot_next   = '0;
                            status_next = cqf_pkg::ST_OVERFLOW;
                            full_next   = 1'b1;
                        end
                        else
                        begin
                            ram_we      = 1'b1;
                            tail_next   = adv_out;
                            count_next  = count_reg + IDX_W'(1);
                            slot_next   = cqf_pkg::SLOT_W'(adv_out);
                            status_next = cqf_pkg::ST_OK;
                            full_next   = (count_next == last_slot_reg);
                        end
                    end
                end
                else if (q_empty)
                begin
                    // Underflow or traverse of an empty queue
                    if (out_free)
                    begin
                        load       = 1'b1;
                        slot_next  = '0;
                        last_next  = 1'b1;
                        empty_next = 1'b1;
                        full_next  = 1'b0;
                        state_next = cqf_pkg::SEQ_IDLE;
                        if (kind_reg == cqf_pkg::KIND_DEQ)
                        begin
                            value_next  = cqf_pkg::UNDERFLOW_VALUE;
                            status_next = cqf_pkg::ST_UNDERFLOW;
                        end
                        else
                        begin
                            value_next  = '0;
                            status_next = cqf_pkg::ST_TRAV_EMPTY;
                        end
                    end
                end
                else
                begin
                    // Read the slot after the head; a dequeue also moves the head
                    ram_re      = 1'b1;
                    ptr_next    = adv_out;
                    single_next = (kind_reg == cqf_pkg::KIND_DEQ);
                    if (kind_reg == cqf_pkg::KIND_DEQ)
                    begin
                        head_next  = adv_out;
                        count_next = count_reg - IDX_W'(1);
                    end
                    state_next = cqf_pkg::SEQ_EMIT;
                end
            end

            cqf_pkg::SEQ_EMIT:
            begin
                // One word per cycle while the response is free; the next read is issued as this one is sent
                adv_in = ptr_reg;
                if (out_free)
                begin
                    load        = 1'b1;
                    value_next  = $signed(ram_rdata);
                    slot_next   = cqf_pkg::SLOT_W'(ptr_reg);
                    status_next = cqf_pkg::ST_OK;
                    last_next   = single_reg || (ptr_reg == tail_reg);
                    empty_next  = q_empty;
                    full_next   = q_full;
                    if (last_next)
                    begin
                        state_next = cqf_pkg::SEQ_IDLE;
                    end
                    else
                    begin
                        ram_re   = 1'b1;
                        ptr_next = adv_out;
                    end
                end
            end

            default:
            begin
                state_next = cqf_pkg::SEQ_IDLE;
            end
        endcase

        // Response register handshake
        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // Control state; a slot count write also empties the queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cqf_pkg::SEQ_IDLE;
            last_slot_reg <= IDX_W'(RING - 1);
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_wr_en)
            begin
                last_slot_reg <= last_slot_next;
                head_reg      <= '0;
                tail_reg      <= '0;
                count_reg     <= '0;
            end
            else
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        single_reg <= single_next;
        kind_reg   <= kind_next;
        data_reg   <= data_next;
        value_reg  <= value_next;
        slot_reg   <= slot_next;
        status_reg <= status_next;
        last_reg   <= last_next;
        empty_reg  <= empty_next;
        full_reg   <= full_next;
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.value      = value_reg;
    assign rsp.slot_index = slot_reg;
    assign rsp.status     = status_reg;
    assign rsp.last       = last_reg;
    assign rsp.is_empty   = empty_reg;
    assign rsp.is_full    = full_reg;

`ifndef SYNTHESIS
    // The fill count never passes the ring capacity
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= last_slot_reg)
        else $error("queue fill count exceeds ring capacity");

    // Head and tail meet exactly when the queue is empty
    a_empty_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) == (head_reg == tail_reg))
        else $error("fill count and ring pointers disagree");

    // A valid operation blocks further commands in the cycle after it is taken
    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready && (cmd.kind == cqf_pkg::KIND_ENQ ||
         cmd.kind == cqf_pkg::KIND_DEQ || cmd.kind == cqf_pkg::KIND_TRAV))
        |=> !cmd.ready)
        else $error("command taken while an operation is in progress");

    // The sequencer only returns to idle with a last result in the register
    a_last_on_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != cqf_pkg::SEQ_IDLE) ##1 (state_reg == cqf_pkg::SEQ_IDLE)
        |-> (rsp_valid_reg && last_reg))
        else $error("operation finished without a last result");
`endif

endmodule
